// ===== hdl/glos_pkg.sv =====
`default_nettype none

package glos_pkg;

  // coordinate and register widths
  localparam int CW           = 6;
  localparam int SIZE_W       = 7;
  localparam int RW           = CW + 3;
  localparam int MAX_SIDE_DEF = 64;
  localparam int SIZE_RESET   = 64;

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WR_MOD,
    ST_WALK,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic setup;
    logic rd_en;
    logic wr_cell;
    logic walk;
    logic load_out;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic bad;
    logic walk_last;
    logic clear_last;
    logic out_free;
    logic cfg_hit;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/glos_ctrl.sv =====
`default_nettype none

module glos_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire glos_pkg::sts_t sts,
  output glos_pkg::cmd_t     cmd,
  output logic               in_stall
);
  import glos_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.bad) begin
          state_next = ST_FINISH;
        end else if (!sts.is_query) begin
          state_next = ST_WR_MOD;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WR_MOD: begin
        state_next = ST_FINISH;
      end
      ST_WALK: begin
        if (sts.walk_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // a size write restarts the map clear
    if (sts.cfg_hit) state_next = ST_CLEAR;
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.setup = 1'b1;
        cmd.rd_en = 1'b1;
      end
      ST_WR_MOD: begin
        cmd.wr_cell = 1'b1;
      end
      ST_WALK: begin
        cmd.walk  = 1'b1;
        cmd.rd_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/glos_dp.sv =====
`default_nettype none

module glos_dp #(
  parameter int MAX_SIDE = glos_pkg::MAX_SIDE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire glos_pkg::cmd_t              cmd,
  output glos_pkg::sts_t                   sts,
  input  wire logic                        opcode,
  input  wire logic [glos_pkg::CW-1:0]     from_x,
  input  wire logic [glos_pkg::CW-1:0]     from_y,
  input  wire logic [glos_pkg::CW-1:0]     to_x,
  input  wire logic [glos_pkg::CW-1:0]     to_y,
  input  wire logic                        rock_flag,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [glos_pkg::SIZE_W-1:0] cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             visible,
  output logic                             status
);
  import glos_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam logic [SIZE_W-1:0] SIZE_CAP =
      (MAX_SIDE > 127) ? SIZE_W'(127) : SIZE_W'(MAX_SIDE);
  localparam logic [SIZE_W-1:0] SIZE_RST =
      (MAX_SIDE < SIZE_RESET) ? SIZE_W'(MAX_SIDE) : SIZE_W'(SIZE_RESET);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_SIDE - 1);

  // grid size registers
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [SIZE_W-1:0] size_sat;

  assign size_sat = (cfg_data > SIZE_CAP) ? SIZE_CAP : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIZE_RST;
      grid_cols <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: grid_rows <= size_sat;
        REG_COLS: grid_cols <= size_sat;
        default:  grid_rows <= grid_rows;
      endcase
    end
  end

  // latched item
  logic          op;
  logic [CW-1:0] fx;
  logic [CW-1:0] fy;
  logic [CW-1:0] tx;
  logic [CW-1:0] ty;
  logic          rock;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op   <= opcode;
      fx   <= from_x;
      fy   <= from_y;
      tx   <= to_x;
      ty   <= to_y;
      rock <= rock_flag;
    end
  end

  logic from_in;
  logic to_in;
  logic bad;

  assign from_in = ({1'b0, fx} < grid_cols) && ({1'b0, fy} < grid_rows);
  assign to_in   = ({1'b0, tx} < grid_cols) && ({1'b0, ty} < grid_rows);
  assign bad     = !from_in || ((op == OP_QUERY) && !to_in);

  // chebyshev distance
  logic [CW-1:0] dx;
  logic [CW-1:0] dy;
  logic [CW-1:0] span;

  assign dx   = (fx >= tx) ? (fx - tx) : (tx - fx);
  assign dy   = (fy >= ty) ? (fy - ty) : (ty - fy);
  assign span = (dx > dy) ? dx : dy;

  // line walk: per axis quotient q and remainder r of (2*num + span) / (2*span)
  logic        [CW-1:0] qx;
  logic        [CW-1:0] qy;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  logic signed [RW-1:0] stepx;
  logic signed [RW-1:0] stepy;
  logic signed [RW-1:0] twodist;
  logic        [CW-1:0] cnt;

  logic signed [RW-1:0] rnx;
  logic signed [RW-1:0] rny;
  logic        [CW-1:0] qx_next;
  logic        [CW-1:0] qy_next;
  logic signed [RW-1:0] rx_next;
  logic signed [RW-1:0] ry_next;

  always_comb begin
    rnx     = rx + stepx;
    qx_next = qx;
    rx_next = rnx;
    if (rnx >= twodist) begin
      qx_next = qx + 1'b1;
      rx_next = rnx - twodist;
    end else if (rnx < $signed(RW'(0))) begin
      qx_next = qx - 1'b1;
      rx_next = rnx + twodist;
    end
  end

  always_comb begin
    rny     = ry + stepy;
    qy_next = qy;
    ry_next = rny;
    if (rny >= twodist) begin
      qy_next = qy + 1'b1;
      ry_next = rny - twodist;
    end else if (rny < $signed(RW'(0))) begin
      qy_next = qy - 1'b1;
      ry_next = rny + twodist;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      qx      <= tx;
      qy      <= ty;
      rx      <= $signed({3'b000, span});
      ry      <= $signed({3'b000, span});
      stepx   <= $signed({2'b00, fx, 1'b0}) - $signed({2'b00, tx, 1'b0});
      stepy   <= $signed({2'b00, fy, 1'b0}) - $signed({2'b00, ty, 1'b0});
      twodist <= $signed({2'b00, span, 1'b0});
      cnt     <= span;
    end else if (cmd.walk) begin
      qx  <= qx_next;
      qy  <= qy_next;
      rx  <= rx_next;
      ry  <= ry_next;
      cnt <= cnt - 1'b1;
    end
  end

  // coordinate to map index
  logic [CW+AW-1:0] fx_ext;
  logic [CW+AW-1:0] fy_ext;
  logic [CW+AW-1:0] qx_ext;
  logic [CW+AW-1:0] qy_ext;
  logic [AW-1:0]    fx_col;
  logic [AW-1:0]    fy_row;
  logic [AW-1:0]    qx_col;
  logic [AW-1:0]    qy_row;

  assign fx_ext = {{AW{1'b0}}, fx};
  assign fy_ext = {{AW{1'b0}}, fy};
  assign qx_ext = {{AW{1'b0}}, qx};
  assign qy_ext = {{AW{1'b0}}, qy};
  assign fx_col = fx_ext[AW-1:0];
  assign fy_row = fy_ext[AW-1:0];
  assign qx_col = qx_ext[AW-1:0];
  assign qy_row = qy_ext[AW-1:0];

  // rock map, one row per word
  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rdata;
  logic [MAX_SIDE-1:0] row_mod;
  logic [MAX_SIDE-1:0] mem_wdata;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       clr_row;

  always_comb begin
    row_mod         = rdata;
    row_mod[fx_col] = rock;
  end

  assign mem_we    = cmd.clear || cmd.wr_cell;
  assign mem_waddr = cmd.clear ? clr_row : fy_row;
  assign mem_wdata = cmd.clear ? '0 : row_mod;
  assign rd_addr   = cmd.walk ? qy_row : fy_row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      clr_row <= '0;
    end else if (cmd.clear) begin
      clr_row <= clr_row + 1'b1;
    end
  end

  // rock check in the cycle after each sample read
  logic          pending;
  logic [AW-1:0] col_d;
  logic          hit;
  logic          hit_all;

  assign hit_all = hit || (pending && rdata[col_d]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      hit     <= 1'b0;
    end else begin
      pending <= cmd.walk;
      hit     <= cmd.setup ? 1'b0 : hit_all;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) col_d <= qx_col;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status  <= bad;
      visible <= (op == OP_QUERY) && !bad && !hit_all;
    end
  end

  assign sts.is_query   = (op == OP_QUERY);
  assign sts.bad        = bad;
  assign sts.walk_last  = (cnt == '0);
  assign sts.clear_last = (clr_row == LAST_ROW);
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.cfg_hit    = cfg_we;

endmodule

`default_nettype wire

// ===== hdl/grid_line_of_sight_unit.sv =====
`default_nettype none

// Rock map over a grid of up to MAX_SIDE x MAX_SIDE cells with a line-of-sight
// query. Each item gives exactly one result (visible, status), unless a size
// write cuts it off first. A write or an out-of-grid item takes no walk; a
// query walks the line between the two cells, whose length is span, the
// Chebyshev distance between them (at most 63 for a 64 x 64 grid), reading one
// sample row per cycle through the single read port of the map. After reset
// and after every size write a clearing pass zeroes the map one row per cycle,
// during which no item is accepted. A finished result waits in an output
// register while the next item is taken in.
module grid_line_of_sight_unit #(
  parameter int MAX_SIDE = glos_pkg::MAX_SIDE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        opcode,
  input  wire logic [glos_pkg::CW-1:0]     from_x,
  input  wire logic [glos_pkg::CW-1:0]     from_y,
  input  wire logic [glos_pkg::CW-1:0]     to_x,
  input  wire logic [glos_pkg::CW-1:0]     to_y,
  input  wire logic                        rock_flag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             visible,
  output logic                             status,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [glos_pkg::SIZE_W-1:0] cfg_data
);
  import glos_pkg::*;

  cmd_t cmd;
  sts_t sts;

  glos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  glos_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .opcode    (opcode),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .rock_flag (rock_flag),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible),
    .status    (status)
  );

  a_rose_needs_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result appeared without a load");

  a_bad_not_visible: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !visible)
    else $error("out-of-grid result marked visible");

  a_cfg_restarts_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall && cmd.clear)
    else $error("size write did not start a map clear");

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.setup, cmd.wr_cell, cmd.walk, cmd.clear, cmd.load_item}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire
